FILE: src/dual_channel_pid_controller_core_defines.svh
// Assertion helpers shared by the controller RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef DUAL_CHANNEL_PID_CONTROLLER_CORE_DEFINES_SVH
`define DUAL_CHANNEL_PID_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication.
`define DCPID_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DCPID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/dcpid_pkg.sv
package dcpid_pkg;

  // Number of control channels with their own integral and previous error.
  localparam int Channels = 2;
  localparam int ChanIdxW = (Channels > 1) ? $clog2(Channels) : 1;

  typedef logic [ChanIdxW-1:0] chan_idx_t;

  localparam int FracBits = 16;
  localparam int PeriodMs = 500;
  localparam int LimitInt = 100;

  localparam logic signed [23:0] DriveMax = 24'(LimitInt * (1 << FracBits));
  localparam logic signed [23:0] DriveMin = -DriveMax;

  // Derivative scaling divides by PeriodMs * 2^FracBits. The power-of-two part
  // (2^FracBits * 4) is a shift; the odd remainder 125 is done by a reciprocal.
  localparam int DivShift   = FracBits + 2;
  localparam int DivOdd     = PeriodMs / 4;
  localparam int DivNumW    = 64 - DivShift;
  localparam int RecipShift = DivNumW + 7;
  localparam logic [63:0] DivRecip =
      ((64'd1 << RecipShift) + 64'(DivOdd - 1)) / 64'(DivOdd);
  localparam logic [22:0] RecipHi = DivRecip[46:24];
  localparam logic [23:0] RecipLo = DivRecip[23:0];

  // Configuration register indexes.
  typedef enum logic [1:0] {
    RegSetpoint  = 2'd0,
    RegGainProp  = 2'd1,
    RegGainInteg = 2'd2,
    RegGainDeriv = 2'd3
  } cfg_reg_e;

  localparam logic signed [31:0] SetpointRst  = 32'sd0;
  localparam logic signed [31:0] GainPropRst  = 32'sd32768;
  localparam logic signed [31:0] GainIntegRst = 32'sd3277;
  localparam logic signed [31:0] GainDerivRst = 32'sd2621440;

  // Error stage result.
  typedef struct packed {
    logic signed [32:0] err;
    logic signed [23:0] integ;
    logic [32:0]        dmag;
    logic               dneg;
  } s1_t;

  // Product stage result.
  typedef struct packed {
    logic signed [64:0] prod_p;
    logic signed [55:0] prod_i;
    logic [63:0]        prod_d;
    logic               dneg;
  } s2_t;

  // Scaled terms, ready to be summed.
  typedef struct packed {
    logic signed [48:0] term_p;
    logic signed [48:0] term_i;
    logic [39:0]        dquot;
    logic               dneg;
  } s4_t;

endpackage

FILE: src/dcpid_state.sv
module dcpid_state (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic               channel_i,
  input  logic signed [31:0] measured_i,
  input  logic signed [31:0] setpoint_i,
  output dcpid_pkg::s1_t     s1_o
);

  logic signed [23:0] integ_q [dcpid_pkg::Channels];
  logic signed [32:0] perr_q  [dcpid_pkg::Channels];

  dcpid_pkg::chan_idx_t idx;
  logic signed [32:0]   err;
  logic signed [33:0]   isum;
  logic signed [23:0]   integ_new;
  logic signed [33:0]   delta;
  logic [33:0]          dabs;
  dcpid_pkg::s1_t       s1_d, s1_q;

  always_comb begin
    // A channel number beyond the last channel is served by the last one.
    if (int'(channel_i) >= dcpid_pkg::Channels) begin
      idx = dcpid_pkg::chan_idx_t'(dcpid_pkg::Channels - 1);
    end else begin
      idx = dcpid_pkg::chan_idx_t'(channel_i);
    end

    err  = {setpoint_i[31], setpoint_i} - {measured_i[31], measured_i};
    isum = {{10{integ_q[idx][23]}}, integ_q[idx]} + {err[32], err};

    if (isum > dcpid_pkg::DriveMax) begin
      integ_new = dcpid_pkg::DriveMax;
    end else if (isum < dcpid_pkg::DriveMin) begin
      integ_new = dcpid_pkg::DriveMin;
    end else begin
      integ_new = isum[23:0];
    end

    delta = {err[32], err} - {perr_q[idx][32], perr_q[idx]};
    dabs  = delta[33] ? -delta : delta;

    s1_d.err   = err;
    s1_d.integ = integ_new;
    s1_d.dmag  = dabs[32:0];
    s1_d.dneg  = delta[33];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < dcpid_pkg::Channels; i++) begin
        integ_q[i] <= '0;
        perr_q[i]  <= '0;
      end
    end else if (load_i) begin
      integ_q[idx] <= integ_new;
      perr_q[idx]  <= err;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s1_q <= s1_d;
    end
  end

  assign s1_o = s1_q;

endmodule

FILE: src/dcpid_mult.sv
module dcpid_mult (
  input  logic               clk_i,
  input  logic               load_i,
  input  dcpid_pkg::s1_t     s1_i,
  input  logic signed [31:0] gain_prop_i,
  input  logic signed [31:0] gain_integ_i,
  input  logic [31:0]        gd_mag_i,
  input  logic               gd_neg_i,
  output dcpid_pkg::s2_t     s2_o
);

  logic signed [64:0] pa, pb;
  logic signed [55:0] ia, ib;
  logic [63:0]        da, db;
  dcpid_pkg::s2_t     s2_d, s2_q;

  always_comb begin
    pa = {{33{gain_prop_i[31]}}, gain_prop_i};
    pb = {{32{s1_i.err[32]}}, s1_i.err};
    ia = {{24{gain_integ_i[31]}}, gain_integ_i};
    ib = {{32{s1_i.integ[23]}}, s1_i.integ};
    da = {32'd0, gd_mag_i};
    db = {31'd0, s1_i.dmag};

    s2_d.prod_p = pa * pb;
    s2_d.prod_i = ia * ib;
    // The magnitude product stays below 2^64 for every input.
    s2_d.prod_d = da * db;
    s2_d.dneg   = s1_i.dneg ^ gd_neg_i;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s2_q <= s2_d;
    end
  end

  assign s2_o = s2_q;

endmodule

FILE: src/dcpid_scale.sv
module dcpid_scale (
  input  logic           clk_i,
  input  logic           load3_i,
  input  logic           load4_i,
  input  dcpid_pkg::s2_t s2_i,
  output dcpid_pkg::s4_t s4_o
);

  typedef struct packed {
    logic signed [48:0] term_p;
    logic signed [48:0] term_i;
    logic [45:0]        pp_hh;
    logic [46:0]        pp_hl;
    logic [45:0]        pp_lh;
    logic [46:0]        pp_ll;
    logic               dneg;
  } s3_t;

  logic [64:0]    pbias;
  logic [63:0]    xi, ibias;
  logic [45:0]    num;
  logic [92:0]    dsum;
  s3_t            s3_d, s3_q;
  dcpid_pkg::s4_t s4_d, s4_q;

  // Truncation toward zero: negative values get 2^16 - 1 added before the shift.
  always_comb begin
    pbias = s2_i.prod_p + (s2_i.prod_p[64] ? 65'((1 << dcpid_pkg::FracBits) - 1) : 65'd0);
    xi    = {{8{s2_i.prod_i[55]}}, s2_i.prod_i} * 64'(dcpid_pkg::PeriodMs);
    ibias = xi + (xi[63] ? 64'((1 << dcpid_pkg::FracBits) - 1) : 64'd0);

    num = s2_i.prod_d[63:dcpid_pkg::DivShift];

    s3_d.term_p = pbias[64:dcpid_pkg::FracBits];
    s3_d.term_i = {ibias[63], ibias[63:dcpid_pkg::FracBits]};
    s3_d.pp_hh  = num[45:23] * dcpid_pkg::RecipHi;
    s3_d.pp_hl  = num[45:23] * dcpid_pkg::RecipLo;
    s3_d.pp_lh  = num[22:0] * dcpid_pkg::RecipHi;
    s3_d.pp_ll  = num[22:0] * dcpid_pkg::RecipLo;
    s3_d.dneg   = s2_i.dneg;
  end

  always_ff @(posedge clk_i) begin
    if (load3_i) begin
      s3_q <= s3_d;
    end
  end

  // Reassemble the reciprocal product; its top bits are the exact quotient.
  always_comb begin
    dsum = 93'({s3_q.pp_hh, 47'd0}) + 93'({s3_q.pp_hl, 23'd0})
         + 93'({s3_q.pp_lh, 24'd0}) + 93'(s3_q.pp_ll);

    s4_d.term_p = s3_q.term_p;
    s4_d.term_i = s3_q.term_i;
    s4_d.dquot  = dsum[92:dcpid_pkg::RecipShift];
    s4_d.dneg   = s3_q.dneg;
  end

  always_ff @(posedge clk_i) begin
    if (load4_i) begin
      s4_q <= s4_d;
    end
  end

  assign s4_o = s4_q;

endmodule

FILE: src/dual_channel_pid_controller_core.sv
// Two-channel PID controller with integral clamp, signed Q16.16.
//
// Input channel (in_valid_i / in_ready_o): one measured sample per item, with
// the channel it belongs to. Output channel (out_valid_o / out_ready_i): one
// drive value per item, clamped to -100..100, in the order items came in.
// Both channels share setpoint and gains, written through the cfg_* port
// (index 0 setpoint, 1 proportional, 2 integral, 3 derivative gain).
//
// The datapath is a six-register pipeline: input register, error and state
// update, products, truncation plus reciprocal partial products, quotient
// assembly, and the output register. One item can enter in every cycle while
// the receiver keeps up. The stage count is set by the derivative divide, done
// as a split reciprocal multiply. Per-channel integral and previous error are
// updated as an item leaves the input register, so items of the same channel
// may follow each other directly.
//
// Reset loads the default gains, clears both channels' state and empties the
// pipeline. When the receiver stalls, bubbles close up first; in_ready_o falls
// only once all six stages hold items.

`include "dual_channel_pid_controller_core_defines.svh"

module dual_channel_pid_controller_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               channel_i,
  input  logic signed [31:0] measured_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [23:0] drive_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [31:0]        cfg_wdata_i
);

  // Configuration. The derivative gain is kept as sign and magnitude, since
  // the derivative path works on magnitudes.
  logic signed [31:0] setpoint_q, gain_prop_q, gain_integ_q;
  logic [31:0]        gd_mag_q;
  logic               gd_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q   <= dcpid_pkg::SetpointRst;
      gain_prop_q  <= dcpid_pkg::GainPropRst;
      gain_integ_q <= dcpid_pkg::GainIntegRst;
      gd_mag_q     <= dcpid_pkg::GainDerivRst;
      gd_neg_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (dcpid_pkg::cfg_reg_e'(cfg_addr_i))
        dcpid_pkg::RegSetpoint:  setpoint_q   <= cfg_wdata_i;
        dcpid_pkg::RegGainProp:  gain_prop_q  <= cfg_wdata_i;
        dcpid_pkg::RegGainInteg: gain_integ_q <= cfg_wdata_i;
        dcpid_pkg::RegGainDeriv: begin
          gd_neg_q <= cfg_wdata_i[31];
          gd_mag_q <= cfg_wdata_i[31] ? -cfg_wdata_i : cfg_wdata_i;
        end
      endcase
    end
  end

  // Pipeline occupancy. Stage 0 is the input register, stage 5 the output.
  logic [5:0] valid_q, valid_d;
  logic [5:0] stage_ready;
  logic [5:0] stage_load;

  always_comb begin
    stage_ready[5] = !valid_q[5] || out_ready_i;
    for (int k = 4; k >= 0; k--) begin
      stage_ready[k] = !valid_q[k] || stage_ready[k + 1];
    end

    stage_load[0] = stage_ready[0] && in_valid_i;
    valid_d[0]    = stage_ready[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < 6; k++) begin
      stage_load[k] = stage_ready[k] && valid_q[k - 1];
      valid_d[k]    = stage_ready[k] ? valid_q[k - 1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Input register.
  logic               channel_q;
  logic signed [31:0] measured_q;

  always_ff @(posedge clk_i) begin
    if (stage_load[0]) begin
      channel_q  <= channel_i;
      measured_q <= measured_i;
    end
  end

  dcpid_pkg::s1_t s1;
  dcpid_pkg::s2_t s2;
  dcpid_pkg::s4_t s4;

  dcpid_state u_state (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (stage_load[1]),
    .channel_i  (channel_q),
    .measured_i (measured_q),
    .setpoint_i (setpoint_q),
    .s1_o       (s1)
  );

  dcpid_mult u_mult (
    .clk_i        (clk_i),
    .load_i       (stage_load[2]),
    .s1_i         (s1),
    .gain_prop_i  (gain_prop_q),
    .gain_integ_i (gain_integ_q),
    .gd_mag_i     (gd_mag_q),
    .gd_neg_i     (gd_neg_q),
    .s2_o         (s2)
  );

  dcpid_scale u_scale (
    .clk_i   (clk_i),
    .load3_i (stage_load[3]),
    .load4_i (stage_load[4]),
    .s2_i    (s2),
    .s4_o    (s4)
  );

  // Final sum of the three terms, saturated to the drive range. The sum is
  // exact at this width, so saturation of large products happens only here.
  logic signed [40:0] term_d;
  logic signed [50:0] total;
  logic signed [23:0] drive_d, drive_q;

  always_comb begin
    term_d = s4.dneg ? -{1'b0, s4.dquot} : {1'b0, s4.dquot};
    total  = {{2{s4.term_p[48]}}, s4.term_p} + {{2{s4.term_i[48]}}, s4.term_i}
           + {{10{term_d[40]}}, term_d};
    if (total > dcpid_pkg::DriveMax) begin
      drive_d = dcpid_pkg::DriveMax;
    end else if (total < dcpid_pkg::DriveMin) begin
      drive_d = dcpid_pkg::DriveMin;
    end else begin
      drive_d = total[23:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_load[5]) begin
      drive_q <= drive_d;
    end
  end

  assign in_ready_o  = stage_ready[0];
  assign out_valid_o = valid_q[5];
  assign drive_o     = drive_q;

  // The saturated drive never leaves the allowed range.
  `DCPID_ASSERT_IMPLY(drive_range_a, out_valid_o,
    (drive_o <= dcpid_pkg::DriveMax) && (drive_o >= dcpid_pkg::DriveMin),
    "drive outside the clamp range")

  // The clamped integral handed to the product stage is within range.
  `DCPID_ASSERT_IMPLY(integ_range_a, valid_q[1],
    (s1.integ <= dcpid_pkg::DriveMax) && (s1.integ >= dcpid_pkg::DriveMin),
    "integral outside the clamp range")

  // With the output register empty, nothing can hold back the input.
  `DCPID_ASSERT_IMPLY(ready_when_drained_a, !out_valid_o, in_ready_o,
    "input stalled while the output register is empty")

  // An item leaving the input register must occupy the error stage next.
  `DCPID_ASSERT_NEXT(advance_a, valid_q[0] && stage_ready[1], valid_q[1],
    "item lost between input register and error stage")

endmodule
